// ----- design/sam_pkg.sv -----
// sam_pkg: shared types and constants for the sprite attribute memory port
// no dependencies; imported by sprite_attribute_memory_port_top
`default_nettype none

package sam_pkg;

   localparam int NUM_SPRITES = 128;
   localparam int SPRITE_W    = $clog2(NUM_SPRITES);
   localparam int HI_DEPTH    = NUM_SPRITES / 4;
   localparam int HI_W        = $clog2(HI_DEPTH);
   localparam int WADDR_W     = 9;
   localparam int BPTR_W      = 10;

   typedef enum logic [1:0] {
      OP_ADDR_LO = 2'd0,
      OP_ADDR_HI = 2'd1,
      OP_DATA_WR = 2'd2,
      OP_READ    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      SLOT_X_LOW = 2'd0,
      SLOT_Y     = 2'd1,
      SLOT_TILE  = 2'd2,
      SLOT_ATTR  = 2'd3
   } slot_type;

endpackage

`default_nettype wire

// ----- design/sprite_attribute_memory_port_top.sv -----
// sprite_attribute_memory_port_top: 128-sprite attribute store behind a byte write port
// depends on sam_pkg
//
//   channel | ports                                            | direction
//   req     | req_valid req_ready req_opcode req_data           | in
//           | req_sprite_index                                  |
//   rsp     | rsp_valid rsp_ready rsp_pos_x rsp_pos_y rsp_tile  | out
//           | rsp_name_table rsp_palette rsp_prio rsp_hflip     |
//           | rsp_vflip rsp_large_res                           |
//
// one item per cycle while the pipeline is not stalled; each taken item passes through the
// registered read of the two sprite memories and then the output register
// reset clears pointers, latches, high table and per-sprite valid bits
// a stalled result holds the read stage; req_ready drops only when both stages are full
`default_nettype none

module sprite_attribute_memory_port_top (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic [1:0]                 req_opcode,
   input  wire logic [7:0]                 req_data,
   input  wire logic [sam_pkg::SPRITE_W-1:0] req_sprite_index,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [8:0]                      rsp_pos_x,
   output logic [7:0]                      rsp_pos_y,
   output logic [7:0]                      rsp_tile,
   output logic                            rsp_name_table,
   output logic [2:0]                      rsp_palette,
   output logic [1:0]                      rsp_prio,
   output logic                            rsp_hflip,
   output logic                            rsp_vflip,
   output logic                            rsp_large_res
);
   import sam_pkg::*;

   // sprite memories: {x_low, y} and {tile, attr}
   logic [15:0] pos_mem  [NUM_SPRITES];
   logic [15:0] attr_mem [NUM_SPRITES];
   logic [NUM_SPRITES-1:0] pos_vld_ff;
   logic [NUM_SPRITES-1:0] attr_vld_ff;
   logic [7:0] hi_ff [HI_DEPTH];

   logic [WADDR_W-1:0] word_address_ff, word_address_in;
   logic [BPTR_W-1:0]  byte_pointer_ff, byte_pointer_in;
   logic [7:0]         x_low_latch_ff, x_low_latch_in;
   logic [7:0]         tile_latch_ff, tile_latch_in;

   // read stage
   logic        s1_valid_ff;
   logic        s1_read_ff;
   logic [15:0] s1_pos_ff;
   logic [15:0] s1_attr_ff;
   logic        s1_pos_vld_ff;
   logic        s1_attr_vld_ff;
   logic [1:0]  s1_hi_ff;

   // output stage
   logic        rsp_valid_ff;
   logic        rsp_read_ff;
   logic [8:0]  pos_x_ff;
   logic [7:0]  pos_y_ff;
   logic [7:0]  tile_ff;
   logic [7:0]  attr_ff;
   logic        large_ff;

   op_type                op;
   slot_type              slot;
   logic                  req_accept;
   logic                  s1_move;
   logic                  low_table;
   logic                  pos_we;
   logic                  attr_we;
   logic                  hi_we;
   logic [SPRITE_W-1:0]   wr_idx;
   logic [HI_W-1:0]       hi_wr_idx;
   logic [HI_W-1:0]       hi_rd_idx;
   logic [7:0]            hi_rd_byte;
   logic [7:0]            pos_x_low;
   logic [7:0]            pos_y_val;
   logic [7:0]            tile_val;
   logic [7:0]            attr_val;

   assign op        = op_type'(req_opcode);
   assign slot      = slot_type'(byte_pointer_ff[1:0]);
   assign s1_move   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || s1_move;
   assign req_accept = req_valid && req_ready;

   assign low_table = !byte_pointer_ff[BPTR_W-1];
   assign wr_idx    = byte_pointer_ff[SPRITE_W+1:2];
   assign hi_wr_idx = byte_pointer_ff[HI_W-1:0];
   assign hi_rd_idx = req_sprite_index[SPRITE_W-1:2];
   assign hi_rd_byte = hi_ff[hi_rd_idx];

   always_comb begin
      word_address_in = word_address_ff;
      byte_pointer_in = byte_pointer_ff;
      x_low_latch_in  = x_low_latch_ff;
      tile_latch_in   = tile_latch_ff;
      pos_we          = 1'b0;
      attr_we         = 1'b0;
      hi_we           = 1'b0;
      if (req_accept) begin
         case (op)
            OP_ADDR_LO: begin
               word_address_in = {word_address_ff[WADDR_W-1], req_data};
               byte_pointer_in = {word_address_in, 1'b0};
            end
            OP_ADDR_HI: begin
               word_address_in = {req_data[0], word_address_ff[WADDR_W-2:0]};
               byte_pointer_in = {word_address_in, 1'b0};
            end
            OP_DATA_WR: begin
               byte_pointer_in = byte_pointer_ff + BPTR_W'(1);
               if (low_table) begin
                  case (slot)
                     SLOT_X_LOW: x_low_latch_in = req_data;
                     SLOT_Y:     pos_we = 1'b1;
                     SLOT_TILE:  tile_latch_in = req_data;
                     SLOT_ATTR:  attr_we = 1'b1;
                     default:    pos_we = 1'b0;
                  endcase
               end else begin
                  hi_we = 1'b1;
               end
            end
            default: begin
               byte_pointer_in = byte_pointer_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_address_ff <= '0;
         byte_pointer_ff <= '0;
         x_low_latch_ff  <= '0;
         tile_latch_ff   <= '0;
         pos_vld_ff      <= '0;
         attr_vld_ff     <= '0;
         for (int i = 0; i < HI_DEPTH; i++) begin
            hi_ff[i] <= '0;
         end
      end else begin
         word_address_ff <= word_address_in;
         byte_pointer_ff <= byte_pointer_in;
         x_low_latch_ff  <= x_low_latch_in;
         tile_latch_ff   <= tile_latch_in;
         if (pos_we) begin
            pos_vld_ff[wr_idx] <= 1'b1;
         end
         if (attr_we) begin
            attr_vld_ff[wr_idx] <= 1'b1;
         end
         if (hi_we) begin
            hi_ff[hi_wr_idx] <= req_data;
         end
      end
   end

   // sprite memories, write-before-next-read so no forwarding is needed
   always_ff @(posedge clock) begin
      if (pos_we) begin
         pos_mem[wr_idx] <= {x_low_latch_ff, req_data};
      end
      if (attr_we) begin
         attr_mem[wr_idx] <= {tile_latch_ff, req_data};
      end
      if (req_accept) begin
         s1_pos_ff      <= pos_mem[req_sprite_index];
         s1_attr_ff     <= attr_mem[req_sprite_index];
         s1_pos_vld_ff  <= pos_vld_ff[req_sprite_index];
         s1_attr_vld_ff <= attr_vld_ff[req_sprite_index];
         s1_hi_ff       <= {hi_rd_byte[{req_sprite_index[1:0], 1'b1}],
                            hi_rd_byte[{req_sprite_index[1:0], 1'b0}]};
         s1_read_ff     <= (op == OP_READ);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   assign pos_x_low = s1_pos_vld_ff  ? s1_pos_ff[15:8]  : 8'h00;
   assign pos_y_val = s1_pos_vld_ff  ? s1_pos_ff[7:0]   : 8'h00;
   assign tile_val  = s1_attr_vld_ff ? s1_attr_ff[15:8] : 8'h00;
   assign attr_val  = s1_attr_vld_ff ? s1_attr_ff[7:0]  : 8'h00;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_move) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move && s1_valid_ff) begin
         rsp_read_ff <= s1_read_ff;
         pos_x_ff    <= s1_read_ff ? {s1_hi_ff[0], pos_x_low} : 9'h000;
         pos_y_ff    <= s1_read_ff ? pos_y_val : 8'h00;
         tile_ff     <= s1_read_ff ? tile_val  : 8'h00;
         attr_ff     <= s1_read_ff ? attr_val  : 8'h00;
         large_ff    <= s1_read_ff ? s1_hi_ff[1] : 1'b0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pos_x      = pos_x_ff;
   assign rsp_pos_y      = pos_y_ff;
   assign rsp_tile       = tile_ff;
   assign rsp_name_table = attr_ff[0];
   assign rsp_palette    = attr_ff[3:1];
   assign rsp_prio       = attr_ff[5:4];
   assign rsp_hflip      = attr_ff[6];
   assign rsp_vflip      = attr_ff[7];
   assign rsp_large_res  = large_ff;

   a_non_read_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_read_ff |-> rsp_pos_x == 9'h000 && rsp_tile == 8'h00
         && rsp_large_res == 1'b0)
      else $error("non-read item carries nonzero fields");

   a_ptr_step: assert property (@(posedge clock) disable iff (reset)
      req_accept && op == OP_DATA_WR |=>
         byte_pointer_ff == $past(byte_pointer_ff) + BPTR_W'(1))
      else $error("byte pointer did not advance on data write");

   a_ptr_reload: assert property (@(posedge clock) disable iff (reset)
      req_accept && (op == OP_ADDR_LO || op == OP_ADDR_HI) |=>
         byte_pointer_ff == {word_address_ff, 1'b0})
      else $error("byte pointer not reloaded from word address");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_move |=> s1_valid_ff && $stable(s1_pos_ff) && $stable(s1_read_ff))
      else $error("read stage lost a stalled item");

endmodule

`default_nettype wire

// ----- tb/sprite_attribute_memory_port_checker.sv -----
`timescale 1ns / 1ps
// sprite_attribute_memory_port_checker: watches the req and rsp channels and keeps its own
// copy of the sprite tables, pointer and latches to predict every result
// depends on sam_pkg; instantiated beside the block by sprite_attribute_memory_port_top_tb
module sprite_attribute_memory_port_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic [1:0]                   req_opcode,
   input  logic [7:0]                   req_data,
   input  logic [sam_pkg::SPRITE_W-1:0] req_sprite_index,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic [8:0]                   rsp_pos_x,
   input  logic [7:0]                   rsp_pos_y,
   input  logic [7:0]                   rsp_tile,
   input  logic                         rsp_name_table,
   input  logic [2:0]                   rsp_palette,
   input  logic [1:0]                   rsp_prio,
   input  logic                         rsp_hflip,
   input  logic                         rsp_vflip,
   input  logic                         rsp_large_res,
   output int                           fail_count,
   output int                           outstanding
);
   import sam_pkg::*;

   typedef struct packed {
      logic [8:0] pos_x;
      logic [7:0] pos_y;
      logic [7:0] tile;
      logic       name_table;
      logic [2:0] palette;
      logic [1:0] prio;
      logic       hflip;
      logic       vflip;
      logic       large_res;
   } sprite_view_type;

   logic [8:0]         spr_x     [NUM_SPRITES];
   logic [7:0]         spr_y     [NUM_SPRITES];
   logic [7:0]         spr_tile  [NUM_SPRITES];
   logic [7:0]         spr_attr  [NUM_SPRITES];
   logic               spr_large [NUM_SPRITES];
   logic [WADDR_W-1:0] word_addr;
   logic [BPTR_W-1:0]  byte_ptr;
   logic [7:0]         x_low_hold;
   logic [7:0]         tile_hold;

   sprite_view_type expected_views [$];
   int              mismatch_total = 0;

   assign fail_count = mismatch_total;

   function automatic sprite_view_type predict_access(input op_type op, input logic [7:0] d,
                                                      input logic [SPRITE_W-1:0] idx);
      sprite_view_type   v;
      logic [BPTR_W-1:0] p;
      int                s;
      int                base;
      v = '0;
      case (op)
         OP_ADDR_LO: begin
            word_addr[7:0] = d;
            byte_ptr = {word_addr, 1'b0};
         end
         OP_ADDR_HI: begin
            word_addr[8] = d[0];
            byte_ptr = {word_addr, 1'b0};
         end
         OP_DATA_WR: begin
            p = byte_ptr;
            if (!p[9]) begin
               s = int'(p[8:2]);
               case (slot_type'(p[1:0]))
                  SLOT_X_LOW: x_low_hold = d;
                  SLOT_Y: begin
                     spr_x[s][7:0] = x_low_hold;
                     spr_y[s] = d;
                  end
                  SLOT_TILE: tile_hold = d;
                  SLOT_ATTR: begin
                     spr_tile[s] = tile_hold;
                     spr_attr[s] = d;
                  end
                  default: ;
               endcase
            end else begin
               // high table and its mirror: four sprites per byte
               base = int'(p[HI_W-1:0]) * 4;
               for (int i = 0; i < 4; i++) begin
                  spr_x[base + i][8] = d[2*i];
                  spr_large[base + i] = d[2*i + 1];
               end
            end
            byte_ptr = p + 1'b1;
         end
         OP_READ: begin
            s = int'(idx);
            v.pos_x      = spr_x[s];
            v.pos_y      = spr_y[s];
            v.tile       = spr_tile[s];
            v.name_table = spr_attr[s][0];
            v.palette    = spr_attr[s][3:1];
            v.prio       = spr_attr[s][5:4];
            v.hflip      = spr_attr[s][6];
            v.vflip      = spr_attr[s][7];
            v.large_res  = spr_large[s];
         end
         default: ;
      endcase
      return v;
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         mismatch_total++;
         if (mismatch_total <= 10)
            $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      sprite_view_type want;
      if (reset) begin
         for (int i = 0; i < NUM_SPRITES; i++) begin
            spr_x[i] = '0;
            spr_y[i] = '0;
            spr_tile[i] = '0;
            spr_attr[i] = '0;
            spr_large[i] = 1'b0;
         end
         word_addr = '0;
         byte_ptr = '0;
         x_low_hold = '0;
         tile_hold = '0;
         expected_views.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_views.size() == 0) begin
               mismatch_total++;
               if (mismatch_total <= 10)
                  $display("%0t: result item with nothing pending", $realtime);
            end else begin
               want = expected_views.pop_front();
               check_field("pos_x", want.pos_x, rsp_pos_x);
               check_field("pos_y", want.pos_y, rsp_pos_y);
               check_field("tile", want.tile, rsp_tile);
               check_field("name_table", want.name_table, rsp_name_table);
               check_field("palette", want.palette, rsp_palette);
               check_field("prio", want.prio, rsp_prio);
               check_field("hflip", want.hflip, rsp_hflip);
               check_field("vflip", want.vflip, rsp_vflip);
               check_field("large_res", want.large_res, rsp_large_res);
            end
         end
         if (req_valid && req_ready)
            expected_views.push_back(predict_access(op_type'(req_opcode), req_data,
                                                    req_sprite_index));
      end
      outstanding <= expected_views.size();
   end

endmodule

// ----- tb/sprite_attribute_memory_port_top_tb.sv -----
`timescale 1ns / 1ps
// sprite_attribute_memory_port_top_tb: clock, reset, req stimulus and rsp back-pressure
// across idle phases; depends on sam_pkg, sprite_attribute_memory_port_top and
// sprite_attribute_memory_port_checker, which predicts and compares
module sprite_attribute_memory_port_top_tb;
   import sam_pkg::*;

   localparam int ITEMS_PER_PHASE = 388;
   localparam int STALL_LIMIT     = 4000;
   localparam int LONG_HOLD       = 300;
   localparam int DRAIN_CYCLES    = 10;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [1:0]          req_opcode;
   logic [7:0]          req_data;
   logic [SPRITE_W-1:0] req_sprite_index;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [8:0]          rsp_pos_x;
   logic [7:0]          rsp_pos_y;
   logic [7:0]          rsp_tile;
   logic                rsp_name_table;
   logic [2:0]          rsp_palette;
   logic [1:0]          rsp_prio;
   logic                rsp_hflip;
   logic                rsp_vflip;
   logic                rsp_large_res;

   int fail_count;
   int outstanding;
   int tx_idle_pct  = 0;
   int rx_stall_pct = 0;
   int hold_left    = 0;
   int items_sent   = 0;
   int quiet_cycles = 0;

   sprite_attribute_memory_port_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_data         (req_data),
      .req_sprite_index (req_sprite_index),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pos_x        (rsp_pos_x),
      .rsp_pos_y        (rsp_pos_y),
      .rsp_tile         (rsp_tile),
      .rsp_name_table   (rsp_name_table),
      .rsp_palette      (rsp_palette),
      .rsp_prio         (rsp_prio),
      .rsp_hflip        (rsp_hflip),
      .rsp_vflip        (rsp_vflip),
      .rsp_large_res    (rsp_large_res)
   );

   sprite_attribute_memory_port_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_data         (req_data),
      .req_sprite_index (req_sprite_index),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pos_x        (rsp_pos_x),
      .rsp_pos_y        (rsp_pos_y),
      .rsp_tile         (rsp_tile),
      .rsp_name_table   (rsp_name_table),
      .rsp_palette      (rsp_palette),
      .rsp_prio         (rsp_prio),
      .rsp_hflip        (rsp_hflip),
      .rsp_vflip        (rsp_vflip),
      .rsp_large_res    (rsp_large_res),
      .fail_count       (fail_count),
      .outstanding      (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // receiver: random stalls, or a long hold-off while hold_left runs down
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left = hold_left - 1;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_item(input op_type op, input logic [7:0] d,
                            input logic [SPRITE_W-1:0] idx);
      if ($urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < tx_idle_pct);
      end
      req_valid        <= 1'b1;
      req_opcode       <= op;
      req_data         <= d;
      req_sprite_index <= idx;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   function automatic logic [7:0] rand_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [SPRITE_W-1:0] rand_sprite();
      return SPRITE_W'($urandom_range(0, NUM_SPRITES - 1));
   endfunction

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_directed();
      send_item(OP_READ, 8'h00, 7'd0);
      send_item(OP_READ, 8'hFF, 7'd127);
      // pointer to 0x3fe: mirrored high table, then wrap to zero
      send_item(OP_ADDR_LO, 8'hFF, 7'd0);
      send_item(OP_ADDR_HI, 8'hFF, 7'd0);
      send_item(OP_DATA_WR, 8'hAA, 7'd0);
      send_item(OP_DATA_WR, 8'h55, 7'd0);
      send_item(OP_DATA_WR, 8'hFF, 7'd0);
      send_item(OP_DATA_WR, 8'h00, 7'd0);
      send_item(OP_DATA_WR, 8'hFF, 7'd0);
      send_item(OP_DATA_WR, 8'hFF, 7'd0);
      send_item(OP_READ, 8'h00, 7'd0);
      send_item(OP_READ, 8'h00, 7'd122);
      send_item(OP_READ, 8'h00, 7'd127);
      // upper data bits of address high ignored
      send_item(OP_ADDR_HI, 8'hFE, 7'd0);
      send_item(OP_ADDR_LO, 8'h00, 7'd0);
      send_item(OP_ADDR_HI, 8'h01, 7'd0);
      send_item(OP_DATA_WR, 8'hFF, 7'd0);
      // pointer 0x220 mirrors high byte zero
      send_item(OP_ADDR_LO, 8'h10, 7'd0);
      send_item(OP_DATA_WR, 8'h03, 7'd0);
      send_item(OP_READ, 8'h00, 7'd0);
      send_item(OP_READ, 8'h00, 7'd1);
      // low write keeps x bit 8
      send_item(OP_ADDR_HI, 8'h00, 7'd0);
      send_item(OP_ADDR_LO, 8'h00, 7'd0);
      send_item(OP_DATA_WR, 8'h5A, 7'd0);
      send_item(OP_DATA_WR, 8'hA5, 7'd0);
      send_item(OP_READ, 8'h00, 7'd0);
   endtask

   task automatic run_random_phase(input int target);
      int                  start;
      int                  pick;
      int                  n;
      logic [SPRITE_W-1:0] spr;
      start = items_sent;
      while (items_sent - start < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            // address then a burst of data bytes
            send_item(OP_ADDR_HI, rand_byte(), rand_sprite());
            send_item(OP_ADDR_LO, rand_byte(), rand_sprite());
            n = $urandom_range(1, 12);
            repeat (n) send_item(OP_DATA_WR, rand_byte(), rand_sprite());
         end else if (pick < 60) begin
            // whole low-table entry of one sprite, then read it back
            spr = rand_sprite();
            send_item(OP_ADDR_HI, rand_byte() & 8'hFE, rand_sprite());
            send_item(OP_ADDR_LO, {spr, 1'b0}, rand_sprite());
            repeat (4) send_item(OP_DATA_WR, rand_byte(), rand_sprite());
            send_item(OP_READ, rand_byte(), spr);
         end else if (pick < 70) begin
            // high table
            send_item(OP_ADDR_HI, rand_byte() | 8'h01, rand_sprite());
            send_item(OP_ADDR_LO, rand_byte(), rand_sprite());
            n = $urandom_range(1, 4);
            repeat (n) send_item(OP_DATA_WR, rand_byte(), rand_sprite());
            send_item(OP_READ, rand_byte(), rand_sprite());
         end else if (pick < 88) begin
            n = $urandom_range(1, 4);
            repeat (n) send_item(OP_READ, rand_byte(), rand_sprite());
         end else begin
            send_item(op_type'($urandom_range(0, 3)), rand_byte(), rand_sprite());
         end
      end
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_opcode       = '0;
      req_data         = '0;
      req_sprite_index = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      run_random_phase(ITEMS_PER_PHASE);
      wait_drained();

      tx_idle_pct = 69;
      run_random_phase(ITEMS_PER_PHASE);
      wait_drained();

      tx_idle_pct  = 0;
      rx_stall_pct = 69;
      hold_left    = LONG_HOLD;
      run_random_phase(ITEMS_PER_PHASE);
      wait_drained();

      tx_idle_pct  = 25;
      rx_stall_pct = 25;
      run_random_phase(ITEMS_PER_PHASE);
      wait_drained();

      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
